/* rtl/core/stochastic_oscillator_macros.svh */
// Assertion macros used by the stochastic oscillator checker.
`ifndef STOCHASTIC_OSCILLATOR_MACROS_SVH
`define STOCHASTIC_OSCILLATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SO_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stochastic_oscillator: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stochastic_oscillator: next-cycle check failed");

`endif

/* rtl/core/stoch_pkg.sv */
// Types and constants of the stochastic oscillator.
package stoch_pkg;

   localparam int CFG_W = 5;
   localparam int K_W   = 15;
   localparam int SUM_W = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] DEFAULT_WINDOW = 5'd8;
   localparam logic [CFG_W-1:0] MIN_WINDOW     = 5'd2;

   // 100 percent in Q7.8.
   localparam logic [K_W-1:0] K_FULL = 15'd25600;

   // Division of the K sum by three: floor(s * 43691 / 2^17) is exact below 2^17.
   localparam logic [15:0] DIV3_RECIP = 16'd43691;
   localparam int DIV3_SHIFT = 17;

   // Word index of the window length register.
   localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_AVG,
      ST_MULD,
      ST_OUT
   } state_type;

endpackage

/* rtl/core/stochastic_oscillator.sv */
// Stochastic oscillator: one price item in, one result item out with high, low, %K and %D.
// The scan covers count = min(samples, window) prices; a flat window skips the divider.
// The window scan reads one stored price per cycle from the history RAM, then a
// 15-step restoring divider forms %K; only one item is in flight at a time.
// Synchronous active-high reset restores window length 8 and an empty history; no clearing pass.
module stochastic_oscillator #(
   parameter int MAX_WINDOW = 16,
   parameter int PRICE_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [PRICE_BITS-1:0]               req_price,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [PRICE_BITS-1:0]               rsp_window_high,
   output logic [PRICE_BITS-1:0]               rsp_window_low,
   output logic [stoch_pkg::K_W-1:0]           rsp_k_value,
   output logic [stoch_pkg::K_W-1:0]           rsp_d_value,
   output logic                                rsp_k_valid,
   output logic                                rsp_d_valid,
   output logic                                rsp_flat_window,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [stoch_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [stoch_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [stoch_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   localparam int PTR_W  = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
   localparam int SEEN_W = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W  = (SEEN_W > stoch_pkg::CFG_W) ? SEEN_W : stoch_pkg::CFG_W;
   localparam int K_W    = stoch_pkg::K_W;
   localparam int NUM_W  = PRICE_BITS + K_W;
   localparam int SUM_W  = stoch_pkg::SUM_W;
   localparam int PROD_W = SUM_W + 16;
   localparam int STEP_W = $clog2(K_W);

   stoch_pkg::state_type state_ff, state_in;

   logic [stoch_pkg::CFG_W-1:0] wreg_ff, wreg_in;
   logic [PTR_W-1:0]            ptr_ff, ptr_in;
   logic [SEEN_W-1:0]           seen_ff, seen_in;
   logic [K_W-1:0]              kh0_ff, kh0_in, kh1_ff, kh1_in;
   logic [1:0]                  vkc_ff, vkc_in;

   logic [PRICE_BITS-1:0]       price_ff, price_in;
   logic [PRICE_BITS-1:0]       hi_ff, hi_in, lo_ff, lo_in;
   logic                        kv_ff, kv_in;
   logic                        flat_ff, flat_in;
   logic [PTR_W-1:0]            rd_addr_ff, rd_addr_in;
   logic [SEEN_W-1:0]           rd_left_ff, rd_left_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic [NUM_W-1:0]            rem_ff, rem_in, den_ff, den_in;
   logic [K_W-1:0]              q_ff, q_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [SUM_W-1:0]            sum_ff, sum_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [PRICE_BITS-1:0]       rsp_hi_ff, rsp_hi_in, rsp_lo_ff, rsp_lo_in;
   logic [K_W-1:0]              rsp_k_ff, rsp_k_in, rsp_d_ff, rsp_d_in;
   logic                        rsp_kv_ff, rsp_kv_in, rsp_dv_ff, rsp_dv_in;
   logic                        rsp_flat_ff, rsp_flat_in;

   logic                        req_take;
   logic                        ram_re;
   logic [PRICE_BITS-1:0]       ram_rdata;
   logic                        csr_write;
   logic [CMP_W-1:0]            wlen, seen_ext, count;

   stoch_ram #(
      .WIDTH (PRICE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_hist (
      .clock (clock),
      .we    (req_take),
      .waddr (ptr_ff),
      .wdata (req_price),
      .re    (ram_re),
      .raddr (rd_addr_ff),
      .rdata (ram_rdata)
   );

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite
                      && (paddr[stoch_pkg::CSR_ADDR_W-1] == stoch_pkg::REG_WINDOW_LENGTH);
   assign prdata    = (paddr[stoch_pkg::CSR_ADDR_W-1] == stoch_pkg::REG_WINDOW_LENGTH)
                      ? stoch_pkg::CSR_DATA_W'(wreg_ff) : '0;

   assign req_stall = (state_ff != stoch_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign ram_re    = (state_ff == stoch_pkg::ST_SCAN) && (rd_left_ff != '0);

   // Effective window: the register clamped to the range 2 to MAX_WINDOW.
   always_comb begin
      wlen = CMP_W'(wreg_ff);
      if (wlen < CMP_W'(stoch_pkg::MIN_WINDOW)) begin
         wlen = CMP_W'(stoch_pkg::MIN_WINDOW);
      end
      if (wlen > CMP_W'(MAX_WINDOW)) begin
         wlen = CMP_W'(MAX_WINDOW);
      end
      seen_ext = (seen_ff < SEEN_W'(MAX_WINDOW)) ? CMP_W'(seen_ff + 1'b1) : CMP_W'(seen_ff);
      count    = (seen_ext < wlen) ? seen_ext : wlen;
   end

   always_comb begin
      state_in     = state_ff;
      wreg_in      = csr_write ? pwdata[stoch_pkg::CFG_W-1:0] : wreg_ff;
      ptr_in       = ptr_ff;
      seen_in      = seen_ff;
      kh0_in       = kh0_ff;
      kh1_in       = kh1_ff;
      vkc_in       = vkc_ff;
      price_in     = price_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      kv_in        = kv_ff;
      flat_in      = flat_ff;
      rd_addr_in   = rd_addr_ff;
      rd_left_in   = rd_left_ff;
      rd_pend_in   = rd_pend_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      q_in         = q_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hi_in    = rsp_hi_ff;
      rsp_lo_in    = rsp_lo_ff;
      rsp_k_in     = rsp_k_ff;
      rsp_d_in     = rsp_d_ff;
      rsp_kv_in    = rsp_kv_ff;
      rsp_dv_in    = rsp_dv_ff;
      rsp_flat_in  = rsp_flat_ff;

      unique case (state_ff)
         stoch_pkg::ST_IDLE: begin
            if (req_take) begin
               price_in   = req_price;
               hi_in      = req_price;
               lo_in      = req_price;
               seen_in    = SEEN_W'(seen_ext);
               kv_in      = (seen_ext >= wlen);
               ptr_in     = (ptr_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
               rd_addr_in = (ptr_ff == '0) ? PTR_W'(MAX_WINDOW - 1) : ptr_ff - 1'b1;
               rd_left_in = SEEN_W'(count - 1'b1);
               rd_pend_in = 1'b0;
               state_in   = stoch_pkg::ST_SCAN;
            end
         end
         stoch_pkg::ST_SCAN: begin
            // Reads are issued back to back; each data word arrives in the following cycle.
            if (rd_pend_ff) begin
               if (ram_rdata > hi_ff) begin
                  hi_in = ram_rdata;
               end
               if (ram_rdata < lo_ff) begin
                  lo_in = ram_rdata;
               end
            end
            rd_pend_in = (rd_left_ff != '0);
            if (rd_left_ff != '0) begin
               rd_left_in = rd_left_ff - 1'b1;
               rd_addr_in = (rd_addr_ff == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_addr_ff - 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = stoch_pkg::ST_MUL;
            end
         end
         stoch_pkg::ST_MUL: begin
            flat_in  = (hi_ff == lo_ff);
            rem_in   = NUM_W'(price_ff - lo_ff) * NUM_W'(stoch_pkg::K_FULL);
            den_in   = NUM_W'(hi_ff - lo_ff) << (K_W - 1);
            q_in     = '0;
            step_in  = STEP_W'(K_W - 1);
            state_in = (hi_ff == lo_ff) ? stoch_pkg::ST_AVG : stoch_pkg::ST_DIV;
         end
         stoch_pkg::ST_DIV: begin
            // The quotient stays below 2^15, so fifteen restoring steps suffice.
            if (rem_ff >= den_ff) begin
               rem_in = rem_ff - den_ff;
               q_in   = {q_ff[K_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[K_W-2:0], 1'b0};
            end
            den_in  = den_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = stoch_pkg::ST_AVG;
            end
         end
         stoch_pkg::ST_AVG: begin
            sum_in   = SUM_W'(q_ff) + SUM_W'(kh0_ff) + SUM_W'(kh1_ff);
            state_in = stoch_pkg::ST_MULD;
         end
         stoch_pkg::ST_MULD: begin
            prod_in  = PROD_W'(sum_ff) * PROD_W'(stoch_pkg::DIV3_RECIP);
            state_in = stoch_pkg::ST_OUT;
         end
         stoch_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hi_in    = hi_ff;
               rsp_lo_in    = lo_ff;
               rsp_k_in     = q_ff;
               rsp_kv_in    = kv_ff;
               rsp_flat_in  = flat_ff;
               rsp_dv_in    = kv_ff && (vkc_ff >= 2'd2);
               rsp_d_in     = (kv_ff && (vkc_ff >= 2'd2))
                              ? K_W'(prod_ff >> stoch_pkg::DIV3_SHIFT) : '0;
               if (kv_ff) begin
                  kh1_in = kh0_ff;
                  kh0_in = q_ff;
                  vkc_in = (vkc_ff == 2'd3) ? vkc_ff : vkc_ff + 1'b1;
               end else begin
                  vkc_in = '0;
               end
               state_in = stoch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stoch_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stoch_pkg::ST_IDLE;
         wreg_ff      <= stoch_pkg::DEFAULT_WINDOW;
         ptr_ff       <= '0;
         seen_ff      <= '0;
         kh0_ff       <= '0;
         kh1_ff       <= '0;
         vkc_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wreg_ff      <= wreg_in;
         ptr_ff       <= ptr_in;
         seen_ff      <= seen_in;
         kh0_ff       <= kh0_in;
         kh1_ff       <= kh1_in;
         vkc_ff       <= vkc_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      price_ff    <= price_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      kv_ff       <= kv_in;
      flat_ff     <= flat_in;
      rd_addr_ff  <= rd_addr_in;
      rd_left_ff  <= rd_left_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      q_ff        <= q_in;
      step_ff     <= step_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      rsp_hi_ff   <= rsp_hi_in;
      rsp_lo_ff   <= rsp_lo_in;
      rsp_k_ff    <= rsp_k_in;
      rsp_d_ff    <= rsp_d_in;
      rsp_kv_ff   <= rsp_kv_in;
      rsp_dv_ff   <= rsp_dv_in;
      rsp_flat_ff <= rsp_flat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_high = rsp_hi_ff;
   assign rsp_window_low  = rsp_lo_ff;
   assign rsp_k_value     = rsp_k_ff;
   assign rsp_d_value     = rsp_d_ff;
   assign rsp_k_valid     = rsp_kv_ff;
   assign rsp_d_valid     = rsp_dv_ff;
   assign rsp_flat_window = rsp_flat_ff;

endmodule

/* rtl/core/stoch_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module stoch_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/stoch_checker.sv */
// Port-level checker for the stochastic oscillator and its bind.
`include "stochastic_oscillator_macros.svh"

module stoch_checker #(
   parameter int PRICE_BITS = 24
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [PRICE_BITS-1:0]     rsp_window_high,
   input logic [PRICE_BITS-1:0]     rsp_window_low,
   input logic [stoch_pkg::K_W-1:0] rsp_k_value,
   input logic [stoch_pkg::K_W-1:0] rsp_d_value,
   input logic                      rsp_k_valid,
   input logic                      rsp_d_valid,
   input logic                      rsp_flat_window
);

   // A stalled result item stays offered.
   `SO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `SO_ASSERT_IMPLY(a_flat_k_zero, clock, reset, rsp_valid && rsp_flat_window, rsp_k_value == '0)

   `SO_ASSERT_IMPLY(a_high_over_low, clock, reset, rsp_valid, rsp_window_high >= rsp_window_low)

   // %D needs a full window, and an invalid %D reads as zero.
   `SO_ASSERT_IMPLY(a_d_needs_k, clock, reset, rsp_valid && !rsp_d_valid, rsp_d_value == '0)

   `SO_ASSERT_IMPLY(a_k_range, clock, reset, rsp_valid,
      (rsp_k_value <= stoch_pkg::K_FULL) && (rsp_d_value <= stoch_pkg::K_FULL)
      && (rsp_k_valid || !rsp_d_valid))

endmodule

bind stochastic_oscillator stoch_checker #(
   .PRICE_BITS (PRICE_BITS)
) u_stoch_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_window_high (rsp_window_high),
   .rsp_window_low  (rsp_window_low),
   .rsp_k_value     (rsp_k_value),
   .rsp_d_value     (rsp_d_value),
   .rsp_k_valid     (rsp_k_valid),
   .rsp_d_valid     (rsp_d_valid),
   .rsp_flat_window (rsp_flat_window)
);

/* test/testbench.sv */
// Self-checking testbench for the stochastic oscillator: a directed table, then random price streams.
module testbench;

   localparam int PRICE_W      = 24;
   localparam int DEPTH        = 16;
   localparam int K_W          = stoch_pkg::K_W;
   localparam int CFG_W        = stoch_pkg::CFG_W;
   localparam int CSR_ADDR_W   = stoch_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W   = stoch_pkg::CSR_DATA_W;
   localparam int RANDOM_ITEMS = 1630;
   localparam int PHASES       = 12;
   localparam int STUCK_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW_LENGTH = {stoch_pkg::REG_WINDOW_LENGTH, 2'b00};

   typedef struct packed {
      logic [PRICE_W-1:0] high;
      logic [PRICE_W-1:0] low;
      logic [K_W-1:0]     k;
      logic [K_W-1:0]     d;
      logic               kv;
      logic               dv;
      logic               flat;
   } osc_result_type;

   typedef enum logic [1:0] {PM_WALK, PM_FLAT, PM_WIDE, PM_EXTREME} price_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [PRICE_W-1:0]    req_price;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PRICE_W-1:0]    rsp_window_high;
   logic [PRICE_W-1:0]    rsp_window_low;
   logic [K_W-1:0]        rsp_k_value;
   logic [K_W-1:0]        rsp_d_value;
   logic                  rsp_k_valid;
   logic                  rsp_d_valid;
   logic                  rsp_flat_window;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   stochastic_oscillator #(
      .MAX_WINDOW(DEPTH),
      .PRICE_BITS(PRICE_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_price(req_price),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_window_high(rsp_window_high),
      .rsp_window_low(rsp_window_low),
      .rsp_k_value(rsp_k_value),
      .rsp_d_value(rsp_d_value),
      .rsp_k_valid(rsp_k_valid),
      .rsp_d_valid(rsp_d_valid),
      .rsp_flat_window(rsp_flat_window),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // Predictor state, a private copy of what the block keeps.
   logic [PRICE_W-1:0] price_ring [DEPTH];
   int                 ring_slot;
   int                 fill_level;
   logic [K_W-1:0]     k_recent [2];
   int                 k_streak;
   logic [CFG_W-1:0]   window_cfg;

   osc_result_type     kd_pending [$];
   int                 items_sent = 0;
   int                 results_seen = 0;
   int                 mismatches = 0;
   int                 partial_count = 0;
   int                 flat_count = 0;
   int                 dvalid_count = 0;
   int                 window_writes = 0;
   bit                 quiet_tail = 1'b0;
   int                 sender_mode = 0;

   price_mode_type     price_mode = PM_WALK;
   int                 run_left = 0;
   logic [PRICE_W-1:0] walk_price = '0;

   // Directed stimulus table.
   logic [CFG_W-1:0]   tbl_window [$];
   logic [PRICE_W-1:0] tbl_price [$];
   bit                 tbl_pinned [$];
   osc_result_type     tbl_result [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic osc_result_type compute_k_d(input logic [PRICE_W-1:0] price);
      osc_result_type     r;
      int                 span;
      int                 count;
      int                 pos;
      logic [PRICE_W-1:0] hi;
      logic [PRICE_W-1:0] lo;
      longint unsigned    num;
      longint unsigned    den;
      longint unsigned    k;
      longint unsigned    avg;
      span = int'(window_cfg);
      if (span < 2) span = 2;
      if (span > DEPTH) span = DEPTH;
      price_ring[ring_slot] = price;
      if (fill_level < DEPTH) fill_level++;
      count = (fill_level < span) ? fill_level : span;
      hi = price;
      lo = price;
      for (int i = 0; i < count; i++) begin
         pos = (ring_slot + DEPTH - i) % DEPTH;
         if (price_ring[pos] > hi) hi = price_ring[pos];
         if (price_ring[pos] < lo) lo = price_ring[pos];
      end
      r = '0;
      r.high = hi;
      r.low = lo;
      r.flat = (hi == lo);
      r.kv = (fill_level >= span);
      k = 0;
      if (!r.flat) begin
         num = price - lo;
         den = hi - lo;
         k = (num * stoch_pkg::K_FULL) / den;
      end
      r.k = k[K_W-1:0];
      if (r.kv) begin
         if (k_streak >= 2) begin
            avg = (k + k_recent[0] + k_recent[1]) / 3;
            r.dv = 1'b1;
            r.d = avg[K_W-1:0];
         end
         k_recent[1] = k_recent[0];
         k_recent[0] = r.k;
         if (k_streak < 3) k_streak++;
      end else begin
         // The %D chain restarts whenever the window is not full.
         k_streak = 0;
      end
      ring_slot = (ring_slot + 1) % DEPTH;
      return r;
   endfunction

   function automatic osc_result_type pinned(input logic [PRICE_W-1:0] hi,
                                             input logic [PRICE_W-1:0] lo,
                                             input int k, input int d, input bit kv, input bit dv,
                                             input bit flat);
      osc_result_type r;
      r.high = hi;
      r.low = lo;
      r.k = K_W'(k);
      r.d = K_W'(d);
      r.kv = kv;
      r.dv = dv;
      r.flat = flat;
      return r;
   endfunction

   task automatic add_row(input logic [CFG_W-1:0] w, input logic [PRICE_W-1:0] p, input bit pin,
                          input osc_result_type r);
      tbl_window.push_back(w);
      tbl_price.push_back(p);
      tbl_pinned.push_back(pin);
      tbl_result.push_back(r);
   endtask

   // Price streams: mostly random walks, with flat runs, wide swings and rail values mixed in.
   function automatic logic [PRICE_W-1:0] next_price();
      int pick;
      if (run_left == 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) price_mode = PM_WALK;
         else if (pick < 7) price_mode = PM_FLAT;
         else if (pick < 9) price_mode = PM_WIDE;
         else price_mode = PM_EXTREME;
         run_left = $urandom_range(4, 30);
         walk_price = PRICE_W'($urandom);
      end
      run_left--;
      case (price_mode)
         PM_WALK: begin
            walk_price = walk_price + PRICE_W'($urandom_range(0, 512)) - PRICE_W'(256);
            return walk_price;
         end
         PM_FLAT: return walk_price;
         PM_WIDE: return PRICE_W'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return '1;
               2: return PRICE_W'(1);
               default: return {{(PRICE_W-1){1'b1}}, 1'b0};
            endcase
         end
      endcase
   endfunction

   task automatic send_price(input logic [PRICE_W-1:0] price, input bit pin,
                             input osc_result_type typed);
      osc_result_type want;
      if (items_sent % 40 == 0) sender_mode = $urandom_range(0, 2);
      if (!quiet_tail && sender_mode != 0 &&
          $urandom_range(0, (sender_mode == 1) ? 7 : 1) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_price <= price;
      do @(posedge clock); while (req_stall);
      want = compute_k_d(price);
      if (pin) want = typed;
      kd_pending.push_back(want);
      items_sent++;
      if (!want.kv) partial_count++;
      if (want.flat) flat_count++;
      if (want.dv) dvalid_count++;
   endtask

   // The sender holds off until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
   endtask

   task automatic program_window(input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_WINDOW_LENGTH;
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      window_cfg = value;
      window_writes++;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (readback !== CSR_DATA_W'(value)) begin
         if (mismatches < 10)
            $display("window length readback: expected %0d, got %0d", value, readback);
         mismatches++;
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      osc_result_type got;
      osc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.high = rsp_window_high;
         got.low = rsp_window_low;
         got.k = rsp_k_value;
         got.d = rsp_d_value;
         got.kv = rsp_k_valid;
         got.dv = rsp_d_valid;
         got.flat = rsp_flat_window;
         results_seen++;
         if (kd_pending.size() == 0) begin
            if (mismatches < 10)
               $display("result %0d arrived with none outstanding: high %h low %h k %0d d %0d",
                        results_seen, got.high, got.low, got.k, got.d);
            mismatches++;
         end else begin
            want = kd_pending.pop_front();
            if (got !== want) begin
               if (mismatches < 10) begin
                  $display("result %0d expected high %h low %h k %0d d %0d kv %b dv %b flat %b",
                           results_seen, want.high, want.low, want.k, want.d, want.kv, want.dv,
                           want.flat);
                  $display("           got high %h low %h k %0d d %0d kv %b dv %b flat %b",
                           got.high, got.low, got.k, got.d, got.kv, got.dv, got.flat);
               end
               mismatches++;
            end
         end
      end
   end

   // Result-side back-pressure in random bursts; none in the final phase.
   initial begin
      int mode;
      int tick;
      mode = 0;
      tick = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 97 == 0) mode = $urandom_range(0, 2);
         if (!quiet_tail && mode != 0 && $urandom_range(0, (mode == 1) ? 15 : 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck = 0;
         else stuck++;
      end
      $display("testbench failed");
      $finish;
   end

   initial begin
      logic [CFG_W-1:0] wsel;
      int               per_phase;
      req_valid <= 1'b0;
      req_price <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      reset <= 1'b1;

      for (int i = 0; i < DEPTH; i++) price_ring[i] = '0;
      ring_slot = 0;
      fill_level = 0;
      k_recent[0] = '0;
      k_recent[1] = '0;
      k_streak = 0;
      window_cfg = stoch_pkg::DEFAULT_WINDOW;

      // Filling window at the reset length, then short and saturated lengths changed mid-stream.
      add_row(5'd8, 24'h000000, 1, pinned(24'h000000, 24'h000000, 0, 0, 0, 0, 1));
      add_row(5'd8, 24'hFFFFFF, 1, pinned(24'hFFFFFF, 24'h000000, 25600, 0, 0, 0, 0));
      add_row(5'd8, 24'h000000, 1, pinned(24'hFFFFFF, 24'h000000, 0, 0, 0, 0, 0));
      add_row(5'd8, 24'hAAAAAA, 0, '0);
      add_row(5'd8, 24'h555555, 0, '0);
      add_row(5'd8, 24'h123456, 0, '0);
      add_row(5'd8, 24'hFEDCBA, 0, '0);
      add_row(5'd8, 24'h000001, 0, '0);
      add_row(5'd8, 24'h7FFFFF, 0, '0);
      add_row(5'd8, 24'h800000, 0, '0);
      add_row(5'd1, 24'h000042, 0, '0);
      add_row(5'd1, 24'h000042, 0, '0);
      add_row(5'd0, 24'h000042, 1, pinned(24'h000042, 24'h000042, 0, 0, 1, 1, 1));
      add_row(5'd31, 24'hFFFFFF, 1, pinned(24'hFFFFFF, 24'h000000, 25600, 0, 0, 0, 0));
      add_row(5'd31, 24'h000000, 1, pinned(24'hFFFFFF, 24'h000000, 0, 0, 0, 0, 0));
      add_row(5'd17, 24'h555555, 0, '0);
      add_row(5'd16, 24'hAAAAAA, 0, '0);
      add_row(5'd16, 24'h000000, 0, '0);
      add_row(5'd2, 24'hFFFFFF, 0, '0);
      add_row(5'd2, 24'hFFFFFF, 0, '0);
      add_row(5'd3, 24'h000001, 0, '0);
      add_row(5'd15, 24'h000002, 0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < tbl_price.size(); i++) begin
         if (tbl_window[i] != window_cfg) begin
            drain_results();
            program_window(tbl_window[i]);
         end
         send_price(tbl_price[i], tbl_pinned[i], tbl_result[i]);
      end

      per_phase = RANDOM_ITEMS / PHASES;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: wsel = 5'd2;
            1: wsel = 5'd16;
            2: wsel = 5'd0;
            3: wsel = 5'd31;
            4: wsel = 5'd1;
            5: wsel = 5'd17;
            6: wsel = 5'd5;
            default: wsel = CFG_W'($urandom_range(0, 31));
         endcase
         drain_results();
         program_window(wsel);
         quiet_tail = (ph == PHASES - 1);
         for (int n = 0; n < per_phase; n++) begin
            send_price(next_price(), 0, '0);
            if ($urandom_range(0, 99) == 0) drain_results();
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d price items over %0d window length writes, lengths 0 to 31 included.",
               items_sent, window_writes);
      $display("Results: %0d with the window filling, %0d flat windows, %0d with %%D valid.",
               partial_count, flat_count, dvalid_count);
      if (mismatches == 0 && kd_pending.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
